/* rtl/core/can_signal_extract_counter_check_assert.svh */
// Assertion macros used by the checker file.
`ifndef CAN_SIGNAL_EXTRACT_COUNTER_CHECK_ASSERT_SVH
`define CAN_SIGNAL_EXTRACT_COUNTER_CHECK_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define CANSX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cansx: %s violated", "lbl");

// Implication checked on every rising edge outside reset.
`define CANSX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cansx: %s violated", "lbl");

`endif

/* rtl/core/cansx_pkg.sv */
package cansx_pkg;

  // Largest frame the receiver delivers, in bytes
  localparam int FrameBytes      = 8;
  // Fail level at which frames are rejected
  localparam int BadCounterLimit = 5;
  // Payload bytes that can ever be looked at
  localparam int LenCap          = (FrameBytes < 8) ? FrameBytes : 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MSB_BIT     = 3'd0,
    REG_LSB_BIT     = 3'd1,
    REG_SIGNAL_SIZE = 3'd2,
    REG_LITTLE_END  = 3'd3,
    REG_SIGNED_VAL  = 3'd4,
    REG_IS_COUNTER  = 3'd5,
    REG_SKIP_CHECK  = 3'd6
  } cansx_reg_e;

  // Input beat
  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  payload_len;
  } cansx_in_t;

  // Output beat
  typedef struct packed {
    logic signed [63:0] raw_value;
    logic               accepted;
    logic               counter_mismatch;
    logic [2:0]         fail_level;
  } cansx_out_t;

  // Signal layout and flags
  typedef struct packed {
    logic [5:0] msb_bit;
    logic [5:0] lsb_bit;
    logic [6:0] signal_size;
    logic       little_endian;
    logic       signed_value;
    logic       is_counter;
    logic       skip_counter_check;
  } cansx_cfg_t;

  // Low n bits set; n of 64 or more gives all ones
  function automatic logic [63:0] width_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

/* rtl/core/cansx_extract.sv */
module cansx_extract import cansx_pkg::*; (
  input  cansx_cfg_t  cfg_i,
  input  logic [63:0] payload_i,
  input  logic [3:0]  payload_len_i,
  output logic [6:0]  width_o,
  output logic [63:0] value_o
);

  logic [3:0]  len_c;
  logic [6:0]  width;
  logic [2:0]  top_byte;
  logic [2:0]  bot_byte;
  logic        alive;
  logic [6:0]  left;
  logic [63:0] acc;
  logic        in_rng;
  logic [3:0]  b_sum;
  logic [3:0]  b_dif;
  logic [2:0]  b;
  logic [2:0]  lo;
  logic [2:0]  hi;
  logic [3:0]  seg;
  logic [7:0]  byte_d;
  logic [7:0]  d8;
  logic [5:0]  sh;
  logic [5:0]  sign_pos;

  // Clamp length and width
  assign len_c    = (payload_len_i > 4'(LenCap)) ? 4'(LenCap) : payload_len_i;
  assign width    = (cfg_i.signal_size > 7'd64) ? 7'd64 : cfg_i.signal_size;
  assign top_byte = cfg_i.msb_bit[5:3];
  assign bot_byte = cfg_i.lsb_bit[5:3];
  assign width_o  = width;

  // Byte walk: eight narrow steps, each live step appends one segment below the gathered bits
  always_comb begin
    alive = 1'b1;
    left  = width;
    acc   = '0;
    for (int s = 0; s < 8; s++) begin
      b_sum  = {1'b0, top_byte} + 4'(s);
      b_dif  = {1'b0, top_byte} - 4'(s);
      in_rng = cfg_i.little_endian ? (4'(s) <= {1'b0, top_byte}) : (b_sum <= 4'd7);
      b      = cfg_i.little_endian ? b_dif[2:0] : b_sum[2:0];
      lo     = (bot_byte == b) ? cfg_i.lsb_bit[2:0] : 3'd0;
      hi     = (top_byte == b) ? cfg_i.msb_bit[2:0] : 3'd7;
      seg    = {1'b0, hi} - {1'b0, lo} + 4'd1;
      byte_d = payload_i[{b, 3'b000} +: 8];
      d8     = (byte_d >> lo) & (8'hFF >> (4'd8 - seg));
      sh     = '0;
      alive  = alive && in_rng && ({1'b0, b} < len_c) && (left != 7'd0);
      if (alive && (hi >= lo)) begin
        // Segment wider than what remains: keep its upper bits only
        if ({3'b000, seg} > left) begin
          d8  = d8 >> (seg - left[3:0]);
          seg = left[3:0];
        end
        sh   = 6'(left - {3'b000, seg});
        acc  = acc | ({56'd0, d8} << sh);
        left = left - {3'b000, seg};
      end
    end
  end

  // Optional sign extension below 64 bits
  assign sign_pos = 6'(width - 7'd1);

  always_comb begin
    value_o = acc;
    if (cfg_i.signed_value && (width != 7'd0) && (width < 7'd64) && acc[sign_pos]) begin
      value_o = acc | ~width_mask(width);
    end
  end

endmodule

/* rtl/core/can_signal_extract_counter_check.sv */
// Path: an accepted input beat passes an input register and then a result register
// before it appears on the output.
// Throughput: one frame per cycle while the output is not stalled; the input register,
// one pass of byte-walk and counter logic, and the output register set the figure.
// Reset: asynchronous, active low; clears both valid flags, the last counter,
// the fail level, and returns the configuration to its documented defaults.
module can_signal_extract_counter_check import cansx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cansx_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cansx_out_t out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  cansx_cfg_t  cfg_q, cfg_d;
  logic        in_vld_q, in_vld_d;
  cansx_in_t   in_q;
  logic        out_vld_q, out_vld_d;
  cansx_out_t  out_q;
  logic [63:0] last_cnt_q, last_cnt_d;
  logic [2:0]  fail_q, fail_d;

  logic        out_free;
  logic        advance;
  logic        in_acc;
  logic [6:0]  width;
  logic [63:0] value;
  logic        chk_en;
  logic [63:0] expect_cnt;
  logic        mismatch;
  cansx_out_t  res;

  // Configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MSB_BIT:     cfg_d.msb_bit            = cfg_wdata_i[5:0];
        REG_LSB_BIT:     cfg_d.lsb_bit            = cfg_wdata_i[5:0];
        REG_SIGNAL_SIZE: cfg_d.signal_size        = cfg_wdata_i;
        REG_LITTLE_END:  cfg_d.little_endian      = cfg_wdata_i[0];
        REG_SIGNED_VAL:  cfg_d.signed_value       = cfg_wdata_i[0];
        REG_IS_COUNTER:  cfg_d.is_counter         = cfg_wdata_i[0];
        REG_SKIP_CHECK:  cfg_d.skip_counter_check = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Handshake: a beat moves forward when the output register is empty or draining
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !advance);
  assign out_vld_d  = advance || (out_vld_q && out_stall_i);

  cansx_extract u_extract (
    .cfg_i         (cfg_q),
    .payload_i     (in_q.payload),
    .payload_len_i (in_q.payload_len),
    .width_o       (width),
    .value_o       (value)
  );

  // Rolling counter check
  assign chk_en     = cfg_q.is_counter && !cfg_q.skip_counter_check;
  assign expect_cnt = (last_cnt_q + 64'd1) & width_mask(width);
  assign mismatch   = chk_en && (expect_cnt != value);

  always_comb begin
    fail_d     = fail_q;
    last_cnt_d = last_cnt_q;
    if (advance && chk_en) begin
      if (mismatch) begin
        fail_d = (fail_q >= 3'(BadCounterLimit)) ? 3'(BadCounterLimit) : fail_q + 3'd1;
      end else if (fail_q != 3'd0) begin
        fail_d = fail_q - 3'd1;
      end
      last_cnt_d = value;
    end
  end

  // Result beat
  always_comb begin
    res.raw_value        = value;
    res.counter_mismatch = mismatch;
    res.fail_level       = chk_en ? fail_d : fail_q;
    res.accepted         = chk_en ? (fail_d < 3'(BadCounterLimit)) : 1'b1;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '{msb_bit: 6'd0, lsb_bit: 6'd0, signal_size: 7'd1,
                      little_endian: 1'b0, signed_value: 1'b0,
                      is_counter: 1'b0, skip_counter_check: 1'b0};
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      last_cnt_q <= '0;
      fail_q     <= '0;
    end else begin
      cfg_q      <= cfg_d;
      in_vld_q   <= in_vld_d;
      out_vld_q  <= out_vld_d;
      last_cnt_q <= last_cnt_d;
      fail_q     <= fail_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/cansx_checker.sv */
`include "can_signal_extract_counter_check_assert.svh"

module cansx_checker import cansx_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input cansx_out_t out_data_o
);

  localparam logic [2:0] LvlCap = 3'(BadCounterLimit);

  logic lvl_ok;
  logic mis_seen;

  assign lvl_ok   = out_data_o.fail_level < LvlCap;
  assign mis_seen = out_valid_o && out_data_o.counter_mismatch;

  // Fail level saturates at the limit
  `CANSX_ASSERT_IMP(a_fail_sat, clk_i, rst_ni, out_valid_o, out_data_o.fail_level <= LvlCap)

  // A mismatch always leaves a non-zero fail level
  `CANSX_ASSERT_IMP(a_mis_level, clk_i, rst_ni, mis_seen, out_data_o.fail_level != 3'd0)

  // On a mismatch, acceptance follows the fail level alone
  `CANSX_ASSERT_IMP(a_mis_acc, clk_i, rst_ni, mis_seen, out_data_o.accepted == lvl_ok)

  // A stalled result beat holds
  `CANSX_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(out_data_o)))

endmodule

bind can_signal_extract_counter_check cansx_checker u_cansx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import cansx_pkg::*;

  localparam int TotalFrames = 1250;
  localparam int HoldCycles  = 100;
  localparam int CycleLimit  = 400000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  cansx_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  cansx_out_t out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = REG_MSB_BIT;
  logic [6:0] cfg_wdata_i = '0;

  can_signal_extract_counter_check u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow of the signal layout and of the rolling counter state
  cansx_cfg_t  layout;
  logic [63:0] last_count;
  logic [2:0]  fail_lvl;
  // Counter value last encoded into a frame on the stimulus side
  logic [63:0] tx_count;

  cansx_in_t  pending_frames[$];
  cansx_out_t expected_extracts[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int frames_queued = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int hold_cnt      = 0;
  bit beat_taken    = 1'b0;
  bit squeeze_on    = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] low_ones(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int sig_width();
    return (layout.signal_size > 7'd64) ? 64 : int'(layout.signal_size);
  endfunction

  // Expected result of one frame; advances the counter state when checking is on
  function automatic cansx_out_t extract_signal(cansx_in_t f);
    int          len, width, left, top, bot, b, lo, hi, seg;
    logic [63:0] val, d, want;
    cansx_out_t  r;
    len   = (f.payload_len > LenCap) ? LenCap : int'(f.payload_len);
    width = sig_width();
    top   = layout.msb_bit;
    bot   = layout.lsb_bit;
    left  = width;
    val   = '0;
    b     = top / 8;
    // byte walk from the msb byte, segments stacked below what is gathered
    while (b >= 0 && b < len && left > 0) begin
      lo = (bot / 8 == b) ? bot : b * 8;
      hi = (top / 8 == b) ? top : b * 8 + 7;
      if (hi >= lo) begin
        seg = hi - lo + 1;
        d   = (f.payload >> lo) & low_ones(seg);
        if (seg > left) begin
          d   = d >> (seg - left);
          seg = left;
        end
        val  = val | (d << (left - seg));
        left = left - seg;
      end
      b = b + (layout.little_endian ? -1 : 1);
    end
    if (layout.signed_value && width > 0 && width < 64) begin
      if (val[width-1]) val = val | ~low_ones(width);
    end
    r.accepted         = 1'b1;
    r.counter_mismatch = 1'b0;
    if (layout.is_counter && !layout.skip_counter_check) begin
      want = (last_count + 64'd1) & low_ones(width);
      if (want != val) begin
        r.counter_mismatch = 1'b1;
        if (fail_lvl < BadCounterLimit) fail_lvl = fail_lvl + 3'd1;
      end else if (fail_lvl > 0) begin
        fail_lvl = fail_lvl - 3'd1;
      end
      last_count = val;
      r.accepted = (fail_lvl < BadCounterLimit);
    end
    r.raw_value  = val;
    r.fail_level = fail_lvl;
    return r;
  endfunction

  // Write v into the payload along the same walk, so the signal reads back as v
  function automatic logic [63:0] place_value(logic [63:0] pl, logic [63:0] v);
    int          top, bot, left, b, lo, hi, seg, base, k;
    logic [63:0] res;
    res  = pl;
    top  = layout.msb_bit;
    bot  = layout.lsb_bit;
    left = sig_width();
    b    = top / 8;
    while (b >= 0 && b < LenCap && left > 0) begin
      lo = (bot / 8 == b) ? bot : b * 8;
      hi = (top / 8 == b) ? top : b * 8 + 7;
      if (hi >= lo) begin
        seg  = hi - lo + 1;
        base = lo;
        if (seg > left) begin
          base = lo + seg - left;
          seg  = left;
        end
        for (k = 0; k < seg; k++) res[base + k] = v[left - seg + k];
        left = left - seg;
      end
      b = b + (layout.little_endian ? -1 : 1);
    end
    return res;
  endfunction

  function automatic cansx_cfg_t make_layout(int msb, int lsb, int size,
                                             bit le, bit sg, bit cnt, bit skip);
    cansx_cfg_t c;
    c.msb_bit            = msb[5:0];
    c.lsb_bit            = lsb[5:0];
    c.signal_size        = size[6:0];
    c.little_endian      = le;
    c.signed_value       = sg;
    c.is_counter         = cnt;
    c.skip_counter_check = skip;
    return c;
  endfunction

  // lsb position of a Motorola signal of the given size starting at msb
  function automatic int motorola_lsb(int msb, int size);
    int left, hi, b;
    left = size;
    hi   = msb;
    b    = msb / 8;
    while (b < 8) begin
      if (hi - b * 8 + 1 >= left) return hi - left + 1;
      left = left - (hi - b * 8 + 1);
      b    = b + 1;
      hi   = b * 8 + 7;
    end
    return 63;
  endfunction

  // Mostly well-formed layouts, some arbitrary bounds and sizes
  function automatic cansx_cfg_t random_layout();
    int msb, lsb, size, r;
    bit le;
    r  = $urandom_range(99);
    le = $urandom_range(1);
    if (r < 15) begin
      msb  = $urandom_range(63);
      lsb  = $urandom_range(63);
      size = $urandom_range(127);
    end else begin
      if (r < 25) size = 64;
      else if (r < 55) size = $urandom_range(64, 1);
      else size = $urandom_range(16, 1);
      if (le) begin
        lsb = $urandom_range(64 - size);
        msb = lsb + size - 1;
      end else begin
        msb = $urandom_range(63);
        lsb = motorola_lsb(msb, size);
      end
    end
    return make_layout(msb, lsb, size, le, $urandom_range(99) < 30,
                       $urandom_range(99) < 45, $urandom_range(99) < 15);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < 50)
      $display("%0t: %s mismatch: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic write_reg(cansx_reg_e idx, logic [6:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
  endtask

  // Only called with the block idle
  task automatic apply_cfg(cansx_cfg_t c);
    write_reg(REG_MSB_BIT,     {1'b0, c.msb_bit});
    write_reg(REG_LSB_BIT,     {1'b0, c.lsb_bit});
    write_reg(REG_SIGNAL_SIZE, c.signal_size);
    write_reg(REG_LITTLE_END,  {6'd0, c.little_endian});
    write_reg(REG_SIGNED_VAL,  {6'd0, c.signed_value});
    write_reg(REG_IS_COUNTER,  {6'd0, c.is_counter});
    write_reg(REG_SKIP_CHECK,  {6'd0, c.skip_counter_check});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    layout   = c;
    tx_count = last_count;
  endtask

  task automatic queue_frame(logic [63:0] payload, int len);
    cansx_in_t f;
    f.payload      = payload;
    f.payload_len  = len[3:0];
    pending_frames = {pending_frames, f};
    frames_queued++;
  endtask

  // Frame carrying the previous counter value plus step
  task automatic push_count(int step, int len);
    logic [63:0] v;
    v = (tx_count + step) & low_ones(sig_width());
    queue_frame(place_value({$urandom, $urandom}, v), len);
    tx_count = v;
  endtask

  task automatic queue_episode(int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (layout.is_counter && !layout.skip_counter_check) begin
        if (r < 80) push_count(1, 8);
        else if (r < 88) queue_frame({$urandom, $urandom}, 8);
        else if (r < 94) repeat ($urandom_range(7, 4)) push_count(2, 8);
        else push_count(1, $urandom_range(15));
      end else begin
        queue_frame({$urandom, $urandom}, (r < 75) ? 8 : $urandom_range(15));
      end
    end
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || expected_extracts.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Driver: beat accepted at the rising edge, predicted and retired
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_extracts = {expected_extracts, extract_signal(in_data_i)};
      void'(pending_frames.pop_front());
      beat_taken = 1'b1;
    end
  end

  // Driver: next beat offered at the falling edge, held while stalled
  always @(negedge clk_i) begin
    if (!in_valid_i || beat_taken) begin
      if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_frames[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // Receiver: one long hold-off when asked, random stalls otherwise
  always @(negedge clk_i) begin
    if (squeeze_on && hold_cnt < HoldCycles) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    cansx_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_extracts.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o.raw_value, '0);
      end else begin
        want = expected_extracts.pop_front();
        if (out_data_o.raw_value !== want.raw_value)
          report_mismatch("raw_value", out_data_o.raw_value, want.raw_value);
        if (out_data_o.accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_data_o.accepted), 64'(want.accepted));
        if (out_data_o.counter_mismatch !== want.counter_mismatch)
          report_mismatch("counter_mismatch", 64'(out_data_o.counter_mismatch),
                          64'(want.counter_mismatch));
        if (out_data_o.fail_level !== want.fail_level)
          report_mismatch("fail_level", 64'(out_data_o.fail_level), 64'(want.fail_level));
      end
    end
  end

  initial begin
    int phase, target;
    layout             = '0;
    layout.signal_size = 7'd1;
    last_count         = '0;
    fail_lvl           = '0;
    tx_count           = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 48;

    // layout out of reset: single bit at position 0
    queue_frame('1, 8);
    queue_frame('0, 8);
    drain();
    // full-width signed Intel signal; over-long and empty frames
    apply_cfg(make_layout(63, 0, 64, 1, 1, 0, 0));
    queue_frame('1, 8);
    queue_frame(64'h8000_0000_0000_0001, 15);
    queue_frame('1, 0);
    drain();
    // full-width Motorola signal, whole and truncated frame
    apply_cfg(make_layout(7, 56, 64, 0, 0, 0, 0));
    queue_frame(64'h0123_4567_89ab_cdef, 8);
    queue_frame(64'hfedc_ba98_7654_3210, 4);
    drain();
    // zero size reads nothing, oversize reads as 64 bits
    apply_cfg(make_layout(63, 0, 0, 1, 1, 0, 0));
    queue_frame('1, 8);
    drain();
    apply_cfg(make_layout(63, 0, 127, 1, 1, 0, 0));
    queue_frame(64'h8000_0000_0000_00ff, 8);
    drain();
    // bounds inverted within the msb byte
    apply_cfg(make_layout(11, 13, 8, 1, 0, 0, 0));
    queue_frame(64'h3fa5, 8);
    drain();
    // byte segment wider than the bits left: only its upper nibble
    apply_cfg(make_layout(15, 0, 4, 1, 0, 0, 0));
    queue_frame(64'hc300, 8);
    drain();
    // 12-bit signed, sign bit set and clear
    apply_cfg(make_layout(11, 0, 12, 1, 1, 0, 0));
    queue_frame(64'h800, 8);
    queue_frame(64'h7ff, 8);
    drain();
    // nibble counter: good run, failures up to saturation and wrap, recovery
    apply_cfg(make_layout(3, 0, 4, 1, 0, 1, 0));
    repeat (3) push_count(1, 8);
    repeat (6) push_count(2, 8);
    push_count(1, 8);
    drain();
    apply_cfg(make_layout(3, 0, 4, 1, 0, 1, 1));
    push_count(2, 8);
    drain();
    // 64-bit counter rolling over from all ones
    apply_cfg(make_layout(63, 0, 64, 1, 0, 1, 0));
    tx_count = '1;
    push_count(0, 8);
    push_count(1, 8);
    drain();

    // random layouts in three idling regimes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          squeeze_on    = 1'b1;
        end
      endcase
      target = frames_queued + TotalFrames / 3;
      while (frames_queued < target) begin
        apply_cfg(random_layout());
        queue_episode($urandom_range(60, 10));
        drain();
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cansx_pkg.sv
rtl/core/cansx_extract.sv
rtl/core/can_signal_extract_counter_check.sv
rtl/core/cansx_checker.sv
dv/tb.sv
